// ----- hdl/glp_pkg.sv -----
// Shared constants, key tables and record type for the glyph line parser.
`timescale 1ns / 1ps
`default_nettype none

package glp_pkg;

    // Width of one stored field
    localparam int FIELD_W = 32;

    // Stored keys, in store order: x, y, width, height, id
    localparam int NUM_KEYS = 5;
    localparam int KEY_MAX  = 6;

    // Number of leading lines that are only counted
    localparam logic [2:0] HEADER_LINES = 3'd4;

    // Key lengths and spellings (unused characters are zero)
    localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{3'd1, 3'd1, 3'd5, 3'd6, 3'd2};
    localparam logic [7:0] KEY_WORD [NUM_KEYS][KEY_MAX] = '{
        '{"x", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "i", "d", "t", "h", 8'h00},
        '{"h", "e", "i", "g", "h", "t"},
        '{"i", "d", 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // One output record
    typedef struct packed {
        logic signed [FIELD_W-1:0] glyph_x;
        logic signed [FIELD_W-1:0] glyph_y;
        logic signed [FIELD_W-1:0] glyph_width;
        logic signed [FIELD_W-1:0] glyph_height;
        logic signed [FIELD_W-1:0] glyph_code;
    } glyph_rec_t;

endpackage

`default_nettype wire

// ----- hdl/glp_in_if.sv -----
// Character input channel: valid/ready with one text byte or end-of-line marker.
`timescale 1ns / 1ps
`default_nettype none

interface glp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] character;

    modport source (output valid, kind, character, input ready);
    modport sink   (input valid, kind, character, output ready);
endinterface

`default_nettype wire

// ----- hdl/glp_out_if.sv -----
// Record output channel: valid/ready with the five stored glyph fields.
`timescale 1ns / 1ps
`default_nettype none

interface glp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [glp_pkg::FIELD_W-1:0] glyph_x;
    logic signed [glp_pkg::FIELD_W-1:0] glyph_y;
    logic signed [glp_pkg::FIELD_W-1:0] glyph_width;
    logic signed [glp_pkg::FIELD_W-1:0] glyph_height;
    logic signed [glp_pkg::FIELD_W-1:0] glyph_code;

    modport source (output valid, glyph_x, glyph_y, glyph_width, glyph_height, glyph_code,
                    input ready);
    modport sink   (input valid, glyph_x, glyph_y, glyph_width, glyph_height, glyph_code,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/glp_line_parser.sv -----
// Per-character parser state: key matching, value conversion and field store.
`timescale 1ns / 1ps
`default_nettype none

module glp_line_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic                kind,
    input  wire logic [7:0]          character,
    output logic                     rec_due,
    output glp_pkg::glyph_rec_t      rec
);

    localparam logic KIND_EOL = 1'b1;

    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } value_phase_t;

    localparam logic [glp_pkg::NUM_KEYS-1:0] ALL_KEYS = '1;

    logic                                after_equal_reg, after_equal_next;
    logic                                last_space_reg, last_space_next;
    logic [2:0]                          key_pos_reg, key_pos_next;
    logic [glp_pkg::NUM_KEYS-1:0]        key_match_reg, key_match_next;
    logic [glp_pkg::FIELD_W-1:0]         value_acc_reg, value_acc_next;
    logic                                value_neg_reg, value_neg_next;
    value_phase_t                        value_phase_reg, value_phase_next;
    logic [2:0]                          line_cnt_reg, line_cnt_next;
    logic [glp_pkg::FIELD_W-1:0]         field_reg  [glp_pkg::NUM_KEYS];
    logic [glp_pkg::FIELD_W-1:0]         field_next [glp_pkg::NUM_KEYS];

    logic                                header_done;
    logic                                is_space;
    logic                                is_digit;
    logic [glp_pkg::FIELD_W-1:0]         acc_step;
    logic [glp_pkg::FIELD_W-1:0]         commit_val;

    assign header_done = (line_cnt_reg >= glp_pkg::HEADER_LINES);
    assign is_space    = character inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    assign is_digit    = character inside {[CH_ZERO:CH_NINE]};

    // acc * 10 + digit, wrapping at 32 bits
    assign acc_step = (value_acc_reg << 3) + (value_acc_reg << 1)
                    + {{(glp_pkg::FIELD_W-4){1'b0}}, character[3:0]};
    assign commit_val = value_neg_reg ? (~value_acc_reg + 1'b1) : value_acc_reg;

    // Record goes out on an end of line once the header is behind us
    assign rec_due = (kind == KIND_EOL) && header_done;

    assign rec.glyph_x      = field_reg[0];
    assign rec.glyph_y      = field_reg[1];
    assign rec.glyph_width  = field_reg[2];
    assign rec.glyph_height = field_reg[3];
    assign rec.glyph_code   = field_reg[4];

    // Next-state logic for one request
    always_comb
    begin
        logic hit;
        hit              = 1'b0;
        after_equal_next = after_equal_reg;
        last_space_next  = last_space_reg;
        key_pos_next     = key_pos_reg;
        key_match_next   = key_match_reg;
        value_acc_next   = value_acc_reg;
        value_neg_next   = value_neg_reg;
        value_phase_next = value_phase_reg;
        line_cnt_next    = line_cnt_reg;
        field_next       = field_reg;

        if (step)
        begin
            if (kind == KIND_EOL)
            begin
                // End of line: drop any pending token, count header lines
                after_equal_next = 1'b0;
                last_space_next  = 1'b1;
                key_pos_next     = '0;
                key_match_next   = ALL_KEYS;
                value_acc_next   = '0;
                value_neg_next   = 1'b0;
                value_phase_next = PH_START;
                if (!header_done)
                begin
                    line_cnt_next = line_cnt_reg + 3'd1;
                end
            end
            else if (header_done)
            begin
                if (character == CH_EQUAL)
                begin
                    after_equal_next = 1'b1;
                    last_space_next  = 1'b1;
                end
                else if (is_space)
                begin
                    if (!last_space_reg)
                    begin
                        // End of token: commit to the first fully matched key
                        if (after_equal_reg)
                        begin
                            for (int k = 0; k < glp_pkg::NUM_KEYS; k++)
                            begin
                                if (!hit && key_match_reg[k] &&
                                    key_pos_reg == glp_pkg::KEY_LEN[k])
                                begin
                                    field_next[k] = commit_val;
                                    hit           = 1'b1;
                                end
                            end
                        end
                        key_pos_next     = '0;
                        key_match_next   = ALL_KEYS;
                        value_acc_next   = '0;
                        value_neg_next   = 1'b0;
                        value_phase_next = PH_START;
                        after_equal_next = 1'b0;
                    end
                    last_space_next = 1'b1;
                end
                else
                begin
                    if (after_equal_reg)
                    begin
                        // Value conversion: skip VT/FF, optional sign, digits
                        if (value_phase_reg == PH_START &&
                            (character == CH_VT || character == CH_FF))
                        begin
                            value_phase_next = PH_START;
                        end
                        else if (value_phase_reg == PH_START &&
                                 (character == CH_PLUS || character == CH_MINUS))
                        begin
                            value_neg_next   = (character == CH_MINUS);
                            value_phase_next = PH_SIGN;
                        end
                        else if (value_phase_reg != PH_DONE)
                        begin
                            if (is_digit)
                            begin
                                value_acc_next   = acc_step;
                                value_phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                value_phase_next = PH_DONE;
                            end
                        end
                    end
                    else
                    begin
                        // Key matching against each word at this position
                        for (int k = 0; k < glp_pkg::NUM_KEYS; k++)
                        begin
                            if (key_pos_reg >= glp_pkg::KEY_LEN[k])
                            begin
                                key_match_next[k] = 1'b0;
                            end
                            else if (glp_pkg::KEY_WORD[k][key_pos_reg] != character)
                            begin
                                key_match_next[k] = 1'b0;
                            end
                        end
                        if (key_pos_reg != 3'd7)
                        begin
                            key_pos_next = key_pos_reg + 3'd1;
                        end
                    end
                    last_space_next = 1'b0;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_equal_reg <= 1'b0;
            last_space_reg  <= 1'b1;
            key_pos_reg     <= '0;
            key_match_reg   <= ALL_KEYS;
            value_acc_reg   <= '0;
            value_neg_reg   <= 1'b0;
            value_phase_reg <= PH_START;
            line_cnt_reg    <= '0;
            for (int k = 0; k < glp_pkg::NUM_KEYS; k++)
            begin
                field_reg[k] <= '0;
            end
        end
        else
        begin
            after_equal_reg <= after_equal_next;
            last_space_reg  <= last_space_next;
            key_pos_reg     <= key_pos_next;
            key_match_reg   <= key_match_next;
            value_acc_reg   <= value_acc_next;
            value_neg_reg   <= value_neg_next;
            value_phase_reg <= value_phase_next;
            line_cnt_reg    <= line_cnt_next;
            field_reg       <= field_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/glyph_line_field_parser_core.sv -----
// Glyph-description line parser: per-character input, one record per body line.
//
// chars   : sink channel, one request per text byte (kind 0) or end of line (kind 1).
// records : source channel, one request per end of line after the first four
//           lines, carrying the last stored x, y, width, height and id values.
// A request taken from chars sits in the input register until it is parsed;
// its record (if any) is loaded into the output register as it is parsed and
// shown on records. One request is taken every cycle while the input is not stalled.
// A record held by a stalled receiver stays in the output register; only an
// end-of-line request that would produce a new record waits behind it, and
// chars.ready drops only in that case.
// Reset returns the parser state to its start, clears the line counter and all
// five stored fields to zero, and empties both registers; no clearing pass is needed.
// Fields are kept across lines and change only when a matching key=value
// token is closed by whitespace; a value pending at end of line is dropped.
`timescale 1ns / 1ps
`default_nettype none

module glyph_line_field_parser_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    glp_in_if.sink     chars,
    glp_out_if.source  records
);

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_kind_reg;
    logic [7:0]           s1_char_reg;
    logic                 out_valid_reg, out_valid_next;
    glp_pkg::glyph_rec_t  out_rec_reg;

    logic                 rec_due;
    glp_pkg::glyph_rec_t  rec;
    logic                 out_hold;
    logic                 s1_fire;
    logic                 in_fire;

    // Handshake control
    assign out_hold      = out_valid_reg && !records.ready;
    assign s1_fire       = s1_valid_reg && !(rec_due && out_hold);
    assign chars.ready   = !s1_valid_reg || s1_fire;
    assign in_fire       = chars.valid && chars.ready;
    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = (s1_fire && rec_due) || out_hold;

    glp_line_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_fire),
        .kind      (s1_kind_reg),
        .character (s1_char_reg),
        .rec_due   (rec_due),
        .rec       (rec)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg <= chars.kind;
            s1_char_reg <= chars.character;
        end
        if (s1_fire && rec_due)
        begin
            out_rec_reg <= rec;
        end
    end

    assign records.valid        = out_valid_reg;
    assign records.glyph_x      = out_rec_reg.glyph_x;
    assign records.glyph_y      = out_rec_reg.glyph_y;
    assign records.glyph_width  = out_rec_reg.glyph_width;
    assign records.glyph_height = out_rec_reg.glyph_height;
    assign records.glyph_code   = out_rec_reg.glyph_code;

`ifndef ASSERT_OFF
    // Input stalls only behind a held record
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> (out_valid_reg && !records.ready))
        else $error("input stalled without a held record");

    // A parsed end of line with a record due shows up on the output
    a_record_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && rec_due) |=> records.valid)
        else $error("due record not presented");

    // A new record only comes from a parsed end of line
    a_record_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(records.valid) |-> $past(s1_fire && rec_due))
        else $error("record appeared without an end of line");
`endif

endmodule

`default_nettype wire
